@@ sv/sample_mean_covariance_assert.svh @@
// Assertion macros used by the checker file
`ifndef SAMPLE_MEAN_COVARIANCE_ASSERT_SVH
`define SAMPLE_MEAN_COVARIANCE_ASSERT_SVH
`define SMC_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("%m: implication failed");
`define SMC_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("%m: next-cycle check failed");
`endif

@@ sv/smc_pkg.sv @@
package smc_pkg;
	localparam int Dim = 4;
	localparam int MaxSamples = 1024;
	localparam int MaxColumns = 256;
	localparam int AddrW = $clog2(MaxSamples);
	localparam int CntW = AddrW + 1;
	localparam int SumW = 16 + CntW;
	localparam int AccW = 33 + CntW;

	localparam logic [1:0] KIND_MEAN = 2'd0;
	localparam logic [1:0] KIND_COV = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	localparam logic CFG_TIME_COLUMN = 1'b0;
	localparam logic CFG_BURNIN = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SUM, ST_MEAN_DIV, ST_COV, ST_COV_DIV, ST_EMIT
	} smc_state_t;

	typedef struct packed {
		logic clear;
		logic en;
		logic mode_cov;
	} lane_ctl_t;
endpackage

@@ sv/smc_div.sv @@
// Restoring divider of a signed dividend by an unsigned count, truncation toward zero.
module smc_div import smc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic signed [AccW-1:0] dividend,
	input  logic [CntW-1:0]        divisor,
	output logic                   done,
	output logic signed [47:0]     quotient
);
	localparam int CW = $clog2(AccW + 1);
	logic [AccW-1:0] q_q;
	logic [CntW:0]   r_q;
	logic [CntW-1:0] d_q;
	logic            neg_q;
	logic            busy_q;
	logic [CW-1:0]   cnt_q;
	logic [CntW:0]   trial;
	logic [CntW:0]   rsub;
	logic [AccW-1:0] qneg;

	assign trial = {r_q[CntW-1:0], q_q[AccW-1]};
	assign rsub = trial - {1'b0, d_q};
	assign qneg = neg_q ? (~q_q + AccW'(1)) : q_q;
	assign quotient = 48'(signed'(qneg));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(AccW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= dividend[AccW-1];
			q_q <= dividend[AccW-1] ? (~dividend + AccW'(1)) : dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!rsub[CntW]) begin
				r_q <= rsub;
				q_q <= {q_q[AccW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[AccW-2:0], 1'b0};
			end
		end
	end
endmodule

@@ sv/smc_lane.sv @@
// One accumulator lane: sums elements, or products of centered pairs.
module smc_lane import smc_pkg::*; (
	input  logic                   clk,
	input  lane_ctl_t              ctl,
	input  logic signed [15:0]     a,
	input  logic signed [15:0]     b,
	input  logic signed [15:0]     mean_a,
	input  logic signed [15:0]     mean_b,
	output logic signed [AccW-1:0] acc
);
	logic signed [16:0] da_s1, db_s1;
	logic signed [33:0] prod_s2;
	logic               en_s1, en_s2, cov_s1, cov_s2;
	logic signed [15:0] a_s1;

	always_ff @(posedge clk) begin
		en_s1 <= ctl.en;
		cov_s1 <= ctl.mode_cov;
		a_s1 <= a;
		da_s1 <= 17'(a) - 17'(mean_a);
		db_s1 <= 17'(b) - 17'(mean_b);
		en_s2 <= en_s1;
		cov_s2 <= cov_s1;
		prod_s2 <= cov_s1 ? 34'(da_s1 * db_s1) : 34'(a_s1);
		if (ctl.clear) acc <= '0;
		else if (en_s2) acc <= acc + AccW'(prod_s2);
	end
endmodule

@@ sv/sample_mean_covariance.sv @@
// Channel | Ports                                   | Handshake
// input   | elem_0..3 column_index sample_end ...   | start && !busy
// result  | kind row col value last                 | strobe, one cycle
// config  | cfg_we cfg_index cfg_data               | cfg_we
// One column per cycle while idle; the input stalls while busy, from stream end until the last result.
// At stream end, busy rises: the samples are summed through four lanes and four divisions
// give the means, then four covariance rows follow, each with a pass and four divisions.
// The store is one memory with a write port and a read port; its read port paces every pass.
// Results leave one per cycle with no back pressure. Reset clears counts, control and config registers.
module sample_mean_covariance import smc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] elem_0,
	input  logic signed [15:0] elem_1,
	input  logic signed [15:0] elem_2,
	input  logic signed [15:0] elem_3,
	input  logic [7:0]         column_index,
	input  logic               sample_end,
	input  logic               stream_end,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [10:0]        cfg_data,
	output logic               strobe,
	output logic [1:0]         kind,
	output logic [1:0]         row,
	output logic [1:0]         col,
	output logic signed [47:0] value,
	output logic               last
);
	logic [7:0]       time_column_q;
	logic [10:0]      burnin_q;
	logic [63:0]      latch_q;
	logic [CntW-1:0]  stored_q;
	logic [63:0]      mem [MaxSamples];
	logic [63:0]      rd_q;
	logic [AddrW-1:0] rd_addr;
	smc_state_t       state_q, state_d;
	logic [CntW-1:0]  ptr_q, n_q;
	logic [2:0]       tail_q;
	logic [1:0]       row_q, sub_q, emit_q;
	logic             div_go_q;
	logic             div_done;
	logic signed [47:0] quot;
	logic signed [15:0] mean_q [Dim];
	logic signed [47:0] res_q [Dim];
	logic [1:0]       emit_kind_q;
	lane_ctl_t        ctl;
	logic signed [AccW-1:0] acc [Dim];
	logic             take;
	logic [63:0]      col_vec;
	logic             match;
	logic             scan_en_q;

	assign take = start && !busy;
	assign col_vec = {elem_3, elem_2, elem_1, elem_0};
	assign match = (32'(column_index) < MaxColumns) && (column_index == time_column_q);
	assign rd_addr = ptr_q[AddrW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_column_q <= '0;
			burnin_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_TIME_COLUMN) time_column_q <= cfg_data[7:0];
			else burnin_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (take && sample_end && stored_q < CntW'(MaxSamples))
			mem[stored_q[AddrW-1:0]] <= match ? col_vec : latch_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= '0;
			stored_q <= '0;
		end else if (take) begin
			if (sample_end || stream_end) latch_q <= '0;
			else if (match) latch_q <= col_vec;
			if (stream_end) stored_q <= '0;
			else if (sample_end && stored_q < CntW'(MaxSamples))
				stored_q <= stored_q + CntW'(1);
		end
	end

	// Lanes: element i, or element row_q against element i.
	for (genvar g = 0; g < Dim; g++) begin : g_lane
		logic signed [15:0] ea, eb;
		assign ea = signed'(rd_q[16*g +: 16]);
		assign eb = signed'(rd_q[16*row_q +: 16]);
		smc_lane u_lane (
			.clk(clk), .ctl(ctl), .a(ea), .b(eb),
			.mean_a(ctl.mode_cov ? mean_q[g] : 16'sd0),
			.mean_b(ctl.mode_cov ? mean_q[row_q] : 16'sd0),
			.acc(acc[g])
		);
	end

	smc_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go_q), .dividend(acc[sub_q]),
		.divisor(n_q), .done(div_done), .quotient(quot)
	);

	logic scan_end;
	assign scan_end = tail_q == 3'd4;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (take && stream_end) begin
				if (burnin_q >= (sample_end && stored_q < CntW'(MaxSamples)
					? stored_q + CntW'(1) : stored_q)) state_d = ST_EMIT;
				else state_d = ST_SUM;
			end
			ST_SUM: if (scan_end) state_d = ST_MEAN_DIV;
			ST_MEAN_DIV: if (div_done && sub_q == 2'(Dim - 1)) state_d = ST_EMIT;
			ST_COV: if (scan_end) state_d = ST_COV_DIV;
			ST_COV_DIV: if (div_done && sub_q == 2'(Dim - 1)) state_d = ST_EMIT;
			ST_EMIT: if (emit_q == 2'(Dim - 1) || emit_kind_q == KIND_ERR) begin
				if (emit_kind_q == KIND_MEAN || (emit_kind_q == KIND_COV
					&& row_q != 2'(Dim - 1))) state_d = ST_COV;
				else state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.clear = (state_q == ST_IDLE) || (state_q == ST_EMIT);
		// the store read is registered, so the lane enable is registered to match it
		ctl.en = scan_en_q;
		ctl.mode_cov = (state_q == ST_COV);
		busy = state_q != ST_IDLE;
	end

	logic [CntW-1:0] end_cnt;
	assign end_cnt = (sample_end && stored_q < CntW'(MaxSamples)) ? stored_q + CntW'(1)
		: stored_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q <= '0;
			n_q <= '0;
			tail_q <= '0;
			row_q <= '0;
			sub_q <= '0;
			emit_q <= '0;
			emit_kind_q <= KIND_MEAN;
			div_go_q <= 1'b0;
			scan_en_q <= 1'b0;
			strobe <= 1'b0;
			last <= 1'b0;
			kind <= KIND_MEAN;
			row <= '0;
			col <= '0;
			value <= '0;
		end else begin
			state_q <= state_d;
			div_go_q <= 1'b0;
			strobe <= 1'b0;
			scan_en_q <= (state_q == ST_SUM || state_q == ST_COV)
				&& ptr_q < n_q + CntW'(burnin_q) && tail_q == 3'd0;
			case (state_q)
				ST_IDLE: begin
					ptr_q <= CntW'(burnin_q);
					n_q <= end_cnt - CntW'(burnin_q);
					tail_q <= '0;
					row_q <= '0;
					emit_q <= '0;
					emit_kind_q <= (state_d == ST_EMIT) ? KIND_ERR : KIND_MEAN;
				end
				ST_SUM, ST_COV: begin
					if (ptr_q < n_q + CntW'(burnin_q) && tail_q == 3'd0)
						ptr_q <= ptr_q + CntW'(1);
					else tail_q <= tail_q + 3'd1;
					if (scan_end) begin
						div_go_q <= 1'b1;
						sub_q <= '0;
						tail_q <= '0;
					end
				end
				ST_MEAN_DIV, ST_COV_DIV: if (div_done) begin
					res_q[sub_q] <= quot;
					if (state_q == ST_MEAN_DIV) mean_q[sub_q] <= quot[15:0];
					if (sub_q != 2'(Dim - 1)) begin
						sub_q <= sub_q + 2'd1;
						div_go_q <= 1'b1;
					end
					emit_q <= '0;
				end
				ST_EMIT: begin
					strobe <= 1'b1;
					kind <= emit_kind_q;
					if (emit_kind_q == KIND_ERR) begin
						row <= '0;
						col <= '0;
						value <= '0;
						last <= 1'b1;
					end else begin
						row <= (emit_kind_q == KIND_MEAN) ? emit_q : row_q;
						col <= (emit_kind_q == KIND_MEAN) ? 2'd0 : emit_q;
						value <= res_q[emit_q];
						last <= emit_kind_q == KIND_COV && row_q == 2'(Dim - 1)
							&& emit_q == 2'(Dim - 1);
					end
					emit_q <= emit_q + 2'd1;
					if (state_d == ST_COV) begin
						ptr_q <= CntW'(burnin_q);
						if (emit_kind_q == KIND_COV) row_q <= row_q + 2'd1;
						emit_kind_q <= KIND_COV;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

@@ sv/smc_checker.sv @@
`include "sample_mean_covariance_assert.svh"
module smc_checker import smc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       stream_end,
	input logic       strobe,
	input logic [1:0] kind,
	input logic       last
);
	`SMC_ASSERT_IMP(a_strobe_busy, clk, arst_n, strobe, busy || last)
	`SMC_ASSERT_NXT(a_end_busy, clk, arst_n, start && !busy && stream_end, busy)
	`SMC_ASSERT_IMP(a_err_last, clk, arst_n, strobe && kind == KIND_ERR, last)
	`SMC_ASSERT_NXT(a_last_gap, clk, arst_n, strobe && last, !strobe)
endmodule

bind sample_mean_covariance smc_checker u_smc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .stream_end(stream_end),
	.strobe(strobe), .kind(kind), .last(last)
);

@@ tb/sample_mean_covariance_test.sv @@
`timescale 1ns / 100ps

module sample_mean_covariance_test;
	import smc_pkg::*;

	typedef struct {
		logic signed [15:0] elems [Dim];
		logic [7:0]         column;
		logic               sample_end;
		logic               stream_end;
		int                 gap;
	} column_txn_t;

	typedef struct {
		logic [1:0]         kind;
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [47:0] value;
		logic               last;
	} stat_txn_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [15:0] elem_0 = '0;
	logic signed [15:0] elem_1 = '0;
	logic signed [15:0] elem_2 = '0;
	logic signed [15:0] elem_3 = '0;
	logic [7:0]         column_index = '0;
	logic               sample_end = 1'b0;
	logic               stream_end = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = CFG_TIME_COLUMN;
	logic [10:0]        cfg_data = '0;
	logic               strobe;
	logic [1:0]         kind;
	logic [1:0]         row;
	logic [1:0]         col;
	logic signed [47:0] value;
	logic               last;

	sample_mean_covariance dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// predictor state
	logic signed [15:0] kept_vectors [MaxSamples][Dim];
	logic signed [15:0] held_column [Dim];
	int                 kept_total;
	logic [7:0]         sel_column;
	int                 burnin;
	stat_txn_t          due_stats [$];

	column_txn_t pending_columns [$];
	column_txn_t staged;
	logic        have_staged = 1'b0;
	int          gap_left = 0;
	logic        took = 1'b0;
	int          mismatches = 0;
	int          cycles = 0;
	bit          no_gaps = 1'b0;

	function automatic void push_stat(logic [1:0] k, int r, int c, longint v, logic l);
		stat_txn_t s;
		s.kind = k;
		s.row = r[1:0];
		s.col = c[1:0];
		s.value = v[47:0];
		s.last = l;
		due_stats.push_back(s);
	endfunction

	function automatic void emit_statistics();
		longint n;
		longint means [Dim];
		longint total;
		longint acc;
		if (burnin >= kept_total) begin
			push_stat(KIND_ERR, 0, 0, 0, 1'b1);
			return;
		end
		n = kept_total - burnin;
		for (int i = 0; i < Dim; i++) begin
			total = 0;
			for (int s = burnin; s < kept_total; s++) total += kept_vectors[s][i];
			means[i] = total / n;
			push_stat(KIND_MEAN, i, 0, means[i], 1'b0);
		end
		for (int i = 0; i < Dim; i++)
			for (int j = 0; j < Dim; j++) begin
				acc = 0;
				for (int s = burnin; s < kept_total; s++)
					acc += (longint'(kept_vectors[s][i]) - means[i]) *
						(longint'(kept_vectors[s][j]) - means[j]);
				push_stat(KIND_COV, i, j, acc / n, i == Dim - 1 && j == Dim - 1);
			end
	endfunction

	function automatic void fold_column(logic signed [15:0] e [Dim], logic [7:0] c,
			logic se, logic sd);
		if (c == sel_column) held_column = e;
		if (se) begin
			// drop samples once the store is full
			if (kept_total < MaxSamples) begin
				kept_vectors[kept_total] = held_column;
				kept_total++;
			end
			foreach (held_column[i]) held_column[i] = '0;
		end
		if (sd) begin
			emit_statistics();
			kept_total = 0;
			foreach (held_column[i]) held_column[i] = '0;
		end
	endfunction

	// monitor: check results, then fold in the accepted transaction
	always @(posedge clk) begin
		stat_txn_t exp_s;
		logic signed [15:0] e [Dim];
		cycles++;
		if (cycles > 400000) begin
			$display("RESULT: ERROR");
			$finish;
		end
		if (arst_n && strobe) begin
			if (due_stats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result kind=%0d row=%0d col=%0d value=%0d",
						kind, row, col, value);
			end else begin
				exp_s = due_stats.pop_front();
				if (kind !== exp_s.kind || row !== exp_s.row || col !== exp_s.col ||
						value !== exp_s.value || last !== exp_s.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%0d/%0d %0d last %0d, got %0d/%0d/%0d %0d last %0d",
							exp_s.kind, exp_s.row, exp_s.col, exp_s.value, exp_s.last,
							kind, row, col, value, last);
				end
			end
		end
		if (arst_n && cfg_we) begin
			if (cfg_index == CFG_TIME_COLUMN) sel_column = cfg_data[7:0];
			else burnin = int'(cfg_data);
		end
		took = arst_n && start && !busy;
		if (took) begin
			e[0] = elem_0;
			e[1] = elem_1;
			e[2] = elem_2;
			e[3] = elem_3;
			fold_column(e, column_index, sample_end, stream_end);
		end
	end

	// driver
	always @(negedge clk) begin
		logic next_start;
		next_start = start;
		if (!start || took) begin
			if (!have_staged && pending_columns.size() > 0) begin
				staged = pending_columns.pop_front();
				have_staged = 1'b1;
				gap_left = staged.gap;
			end
			if (have_staged && gap_left == 0) begin
				elem_0 <= staged.elems[0];
				elem_1 <= staged.elems[1];
				elem_2 <= staged.elems[2];
				elem_3 <= staged.elems[3];
				column_index <= staged.column;
				sample_end <= staged.sample_end;
				stream_end <= staged.stream_end;
				next_start = 1'b1;
				have_staged = 1'b0;
			end else begin
				next_start = 1'b0;
				if (have_staged) gap_left--;
			end
		end
		start <= next_start;
	end

	function automatic logic signed [15:0] pick_elem();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return '0;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic void add_column(logic signed [15:0] e0, logic signed [15:0] e1,
			logic signed [15:0] e2, logic signed [15:0] e3, logic [7:0] c, logic se, logic sd);
		column_txn_t t;
		t.elems[0] = e0;
		t.elems[1] = e1;
		t.elems[2] = e2;
		t.elems[3] = e3;
		t.column = c;
		t.sample_end = se;
		t.stream_end = sd;
		t.gap = no_gaps ? 0 : $urandom_range(0, 4);
		pending_columns.push_back(t);
	endfunction

	task automatic drain();
		wait (pending_columns.size() == 0 && !have_staged);
		@(negedge clk);
		while (start || due_stats.size() != 0 || busy) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [10:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_run(int items);
		logic [7:0] c;
		for (int k = 0; k < items; k++) begin
			// mostly near the kept column so samples carry real data
			c = ($urandom_range(0, 3) == 0) ? 8'($urandom()) :
				8'(sel_column + $urandom_range(0, 2));
			add_column(pick_elem(), pick_elem(), pick_elem(), pick_elem(), c,
				$urandom_range(0, 2) == 0, k == items - 1);
		end
	endtask

	initial begin
		sel_column = '0;
		burnin = 0;
		kept_total = 0;
		foreach (held_column[i]) held_column[i] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, repeated match, no match, empty stream, then burn-in of one
		add_column(16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 8'd0, 1'b1, 1'b0);
		add_column(16'sh8000, 16'sh7fff, -16'sd1, 16'sh5555, 8'd0, 1'b0, 1'b0);
		add_column(16'sh1234, 16'shaaaa, 16'sh00ff, 16'shff00, 8'd0, 1'b1, 1'b0);
		add_column(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 8'd255, 1'b1, 1'b0);
		add_column(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 8'd0, 1'b1, 1'b1);
		drain();
		add_column(16'sh0101, 16'sh0202, 16'sh0303, 16'sh0404, 8'd0, 1'b0, 1'b1);
		drain();
		write_reg(CFG_TIME_COLUMN, 11'd255);
		write_reg(CFG_BURNIN, 11'd1);
		add_column(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 8'd255, 1'b1, 1'b0);
		add_column(16'sh0001, 16'sh0002, 16'sh0003, 16'sh0004, 8'd254, 1'b1, 1'b0);
		add_column(16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 8'd255, 1'b0, 1'b0);
		add_column(16'sh4000, 16'shc000, 16'sh2000, 16'she000, 8'd255, 1'b1, 1'b0);
		add_column(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'd3, 1'b1, 1'b1);
		drain();

		for (int r = 0; r < 40; r++) begin
			if ($urandom_range(0, 2) == 0) begin
				// registers change only with nothing in flight
				drain();
				case ($urandom_range(0, 3))
					0: write_reg(CFG_TIME_COLUMN, 11'd0);
					1: write_reg(CFG_TIME_COLUMN, 11'd255);
					default: write_reg(CFG_TIME_COLUMN, 11'($urandom_range(0, 255)));
				endcase
				write_reg(CFG_BURNIN, ($urandom_range(0, 7) == 0) ?
					11'($urandom_range(0, 1024)) : 11'($urandom_range(0, 2)));
			end
			no_gaps = ($urandom_range(0, 3) == 0);
			random_run($urandom_range(1, 18));
			if ($urandom_range(0, 1) == 0) drain();
		end
		drain();
		repeat (50) @(negedge clk);
		if (mismatches == 0 && due_stats.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
